// ----- rtl/core/cark_pkg.sv -----
// cark_pkg: shared constants, match state types and the matcher result struct
// for the command / acknowledgement retransmit handler; no dependencies
package cark_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned TICKS_W  = 16;
    localparam int unsigned PEND_W   = 8;

    localparam logic [TICKS_W-1:0]  TIMEOUT_RESET = TICKS_W'(300);
    localparam logic [PEND_W-1:0]   PEND_MAX      = '1;

    localparam logic [BYTE_W-1:0] CH_BANG = 8'd33;
    localparam logic [BYTE_W-1:0] CH_R    = 8'd82;
    localparam logic [BYTE_W-1:0] CH_S    = 8'd83;
    localparam logic [BYTE_W-1:0] CH_T    = 8'd84;
    localparam logic [BYTE_W-1:0] CH_HASH = 8'd35;
    localparam logic [BYTE_W-1:0] CH_O    = 8'd79;
    localparam logic [BYTE_W-1:0] CH_K    = 8'd75;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic {
        KIND_NEW    = 1'b0,
        KIND_REPEAT = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        REQ_IDLE,
        REQ_BANG,
        REQ_R,
        REQ_S,
        REQ_T
    } req_state_t;

    typedef enum logic [1:0] {
        ACK_IDLE,
        ACK_BANG,
        ACK_O,
        ACK_K
    } ack_state_t;

    typedef struct packed {
        req_state_t req_state;
        ack_state_t ack_state;
        logic       req_done;
        logic       ack_done;
    } match_result_t;

endpackage

// ----- rtl/core/cark_item_if.sv -----
// cark_item_if: input item channel (received byte or timer tick)
// depends on cark_pkg for field widths
interface cark_item_if;
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic [cark_pkg::BYTE_W-1:0]    rx_byte;
    logic [cark_pkg::SAMPLE_W-1:0]  adc_sample;

    modport source (output valid, output op, output rx_byte, output adc_sample, input ready);
    modport sink   (input valid, input op, input rx_byte, input adc_sample, output ready);
endinterface

// ----- rtl/core/cark_reply_if.sv -----
// cark_reply_if: reply channel (new reading or repeat after timeout)
// depends on cark_pkg for field widths
interface cark_reply_if;
    logic                           valid;
    logic                           ready;
    logic                           reply_kind;
    logic [cark_pkg::SAMPLE_W-1:0]  reply_value;

    modport source (output valid, output reply_kind, output reply_value, input ready);
    modport sink   (input valid, input reply_kind, input reply_value, output ready);
endinterface

// ----- rtl/core/command_ack_retransmit_handler.sv -----
// command_ack_retransmit_handler: request / ack matching with timed resend
// depends on cark_pkg, cark_item_if, cark_reply_if and cark_matcher
//
//  channel   dir  payload                          handshake
//  item      in   op, rx_byte, adc_sample           valid / ready
//  reply     out  reply_kind, reply_value           valid / ready
//  cfg       in   cfg_wdata (timeout_ticks)         cfg_we, no wait
//
// one item per cycle while replies are taken; a transfer lands in the input
// register, goes through the matchers and counters when the output register
// is free or taken, and its reply, if any, waits in it until taken; the input
// register refills while a reply waits, so one stalled reply holds at most
// one more item; reset clears all control state but not the data registers;
// timeout reload and count return to 300
module command_ack_retransmit_handler (
    input  logic                         clk,
    input  logic                         rst_n,
    cark_item_if.sink                    item,
    cark_reply_if.source                 reply,
    input  logic                         cfg_we,
    input  logic [cark_pkg::TICKS_W-1:0] cfg_wdata
);

    logic                           in_valid_reg;
    logic                           in_op_reg;
    logic [cark_pkg::BYTE_W-1:0]    in_byte_reg;
    logic [cark_pkg::SAMPLE_W-1:0]  in_sample_reg;

    logic                           out_valid_reg;
    logic                           out_kind_reg;
    logic [cark_pkg::SAMPLE_W-1:0]  out_value_reg;

    logic [cark_pkg::TICKS_W-1:0]   ticks_reg;
    cark_pkg::req_state_t           req_state_reg, req_state_next;
    cark_pkg::ack_state_t           ack_state_reg, ack_state_next;
    logic [cark_pkg::PEND_W-1:0]    pending_reg, pending_next;
    logic                           awaiting_reg, awaiting_next;
    logic [cark_pkg::TICKS_W-1:0]   count_reg, count_next;
    logic [cark_pkg::SAMPLE_W-1:0]  last_reg, last_next;

    logic                           advance;
    logic                           emit;
    logic                           emit_kind;
    cark_pkg::match_result_t        match;

    assign advance    = in_valid_reg && (!out_valid_reg || reply.ready);
    assign item.ready = !in_valid_reg || advance;

    assign reply.valid       = out_valid_reg;
    assign reply.reply_kind  = out_kind_reg;
    assign reply.reply_value = out_value_reg;

    cark_matcher u_matcher (
        .rx_byte      (in_byte_reg),
        .req_state    (req_state_reg),
        .ack_state    (ack_state_reg),
        .awaiting_ack (awaiting_reg),
        .result       (match)
    );

    always_comb
    begin
        req_state_next = req_state_reg;
        ack_state_next = ack_state_reg;
        pending_next   = pending_reg;
        awaiting_next  = awaiting_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        emit           = 1'b0;
        emit_kind      = cark_pkg::KIND_NEW;

        if (in_op_reg == cark_pkg::OP_BYTE)
        begin
            req_state_next = match.req_state;
            ack_state_next = match.ack_state;
            if (match.req_done && pending_reg != cark_pkg::PEND_MAX)
            begin
                pending_next = pending_reg + 1'b1;
            end
            if (match.ack_done)
            begin
                count_next    = ticks_reg;
                awaiting_next = 1'b0;
            end
        end
        else if (awaiting_reg)
        begin
            if (count_reg == '0)
            begin
                count_next = ticks_reg;
                emit       = 1'b1;
                emit_kind  = cark_pkg::KIND_REPEAT;
            end
            else
            begin
                count_next = count_reg - 1'b1;
            end
        end

        if (!emit && pending_next != '0 && !awaiting_next)
        begin
            pending_next  = pending_next - 1'b1;
            last_next     = in_sample_reg;
            awaiting_next = 1'b1;
            emit          = 1'b1;
            emit_kind     = cark_pkg::KIND_NEW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ticks_reg     <= cark_pkg::TIMEOUT_RESET;
            req_state_reg <= cark_pkg::REQ_IDLE;
            ack_state_reg <= cark_pkg::ACK_IDLE;
            pending_reg   <= '0;
            awaiting_reg  <= 1'b0;
            count_reg     <= cark_pkg::TIMEOUT_RESET;
            last_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                ticks_reg <= cfg_wdata;
            end

            if (item.ready)
            begin
                in_valid_reg <= item.valid;
            end

            if (advance)
            begin
                out_valid_reg <= emit;
                req_state_reg <= req_state_next;
                ack_state_reg <= ack_state_next;
                pending_reg   <= pending_next;
                awaiting_reg  <= awaiting_next;
                count_reg     <= count_next;
                last_reg      <= last_next;
            end
            else if (reply.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_op_reg     <= item.op;
            in_byte_reg   <= item.rx_byte;
            in_sample_reg <= item.adc_sample;
        end
        if (advance && emit)
        begin
            out_kind_reg  <= emit_kind;
            out_value_reg <= (emit_kind == cark_pkg::KIND_REPEAT) ? last_reg : last_next;
        end
    end

endmodule

// ----- rtl/core/cark_matcher.sv -----
// cark_matcher: next state of the "!RST#" and "!OK#" matchers for one byte
// depends on cark_pkg for characters, state types and the result struct
module cark_matcher (
    input  logic [cark_pkg::BYTE_W-1:0] rx_byte,
    input  cark_pkg::req_state_t        req_state,
    input  cark_pkg::ack_state_t        ack_state,
    input  logic                        awaiting_ack,
    output cark_pkg::match_result_t     result
);

    always_comb
    begin
        result.req_done = 1'b0;
        result.ack_done = 1'b0;

        if (rx_byte == cark_pkg::CH_BANG)
        begin
            result.req_state = cark_pkg::REQ_BANG;
        end
        else if (req_state == cark_pkg::REQ_BANG && rx_byte == cark_pkg::CH_R)
        begin
            result.req_state = cark_pkg::REQ_R;
        end
        else if (req_state == cark_pkg::REQ_R && rx_byte == cark_pkg::CH_S)
        begin
            result.req_state = cark_pkg::REQ_S;
        end
        else if (req_state == cark_pkg::REQ_S && rx_byte == cark_pkg::CH_T)
        begin
            result.req_state = cark_pkg::REQ_T;
        end
        else if (req_state == cark_pkg::REQ_T && rx_byte == cark_pkg::CH_HASH)
        begin
            result.req_state = cark_pkg::REQ_IDLE;
            result.req_done  = 1'b1;
        end
        else
        begin
            result.req_state = cark_pkg::REQ_IDLE;
        end

        if (rx_byte == cark_pkg::CH_BANG && awaiting_ack)
        begin
            result.ack_state = cark_pkg::ACK_BANG;
        end
        else if (ack_state == cark_pkg::ACK_BANG && rx_byte == cark_pkg::CH_O)
        begin
            result.ack_state = cark_pkg::ACK_O;
        end
        else if (ack_state == cark_pkg::ACK_O && rx_byte == cark_pkg::CH_K)
        begin
            result.ack_state = cark_pkg::ACK_K;
        end
        else if (ack_state == cark_pkg::ACK_K && rx_byte == cark_pkg::CH_HASH)
        begin
            result.ack_state = cark_pkg::ACK_IDLE;
            result.ack_done  = 1'b1;
        end
        else
        begin
            result.ack_state = cark_pkg::ACK_IDLE;
        end
    end

endmodule

// ----- tb/command_ack_retransmit_handler_tb.sv -----
// command_ack_retransmit_handler_tb: self-checking bench for the request / ack
// handler with timed resend; a scripted opening, then random traffic per timeout
// setting; depends on cark_pkg, cark_item_if, cark_reply_if and the handler rtl
`timescale 1ns / 100ps

module command_ack_retransmit_handler_tb;
    import cark_pkg::*;

    localparam int unsigned SCRIPT_LEN    = 26;
    localparam int unsigned PHASE_ITEMS   = 147;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_CYCLES  = 10;
    localparam int unsigned QUIET_LIMIT   = 5000;

    localparam logic [39:0] REQUEST_TEXT = {CH_BANG, CH_R, CH_S, CH_T, CH_HASH};
    localparam logic [39:0] ACK_TEXT     = {8'h00, CH_BANG, CH_O, CH_K, CH_HASH};

    // slot 6 is replaced by a random reload at run time
    localparam logic [7:0][15:0] RELOAD_PLAN = {16'd2, 16'd0, 16'd6, 16'd3,
                                                16'd1, 16'd2, 16'd65535, 16'd0};

    typedef struct packed {
        kind_t               kind;
        logic [SAMPLE_W-1:0] value;
    } reply_t;

    typedef struct packed {
        op_t                 op;
        logic [BYTE_W-1:0]   rx;
        logic [SAMPLE_W-1:0] smp;
        logic                pinned;
        logic                hit;
        reply_t              due;
    } script_row_t;

    typedef enum {
        STALL_NONE,
        STALL_COIN,
        STALL_PATTERN,
        STALL_RARE
    } stall_mode_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [TICKS_W-1:0]  cfg_wdata;

    cark_item_if  item_ch ();
    cark_reply_if reply_ch ();

    command_ack_retransmit_handler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .reply     (reply_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    req_state_t          req_st     = REQ_IDLE;
    ack_state_t          ack_st     = ACK_IDLE;
    logic [PEND_W-1:0]   pend       = '0;
    logic                waiting    = 1'b0;
    logic [TICKS_W:0]    tmo_count  = {1'b0, TIMEOUT_RESET};
    logic [TICKS_W-1:0]  tmo_reload = TIMEOUT_RESET;
    logic [SAMPLE_W-1:0] held_value = '0;

    reply_t       due_replies [$];
    script_row_t  script [SCRIPT_LEN];
    int unsigned  burst_left  = 0;
    int unsigned  items_sent  = 0;
    int unsigned  error_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void predict_reply(input op_t op, input logic [BYTE_W-1:0] rx,
                                          input logic [SAMPLE_W-1:0] smp,
                                          output bit hit, output reply_t r);
        hit = 1'b0;
        r   = '0;
        if (op == OP_BYTE)
        begin
            if (rx == CH_BANG)
                req_st = REQ_BANG;
            else if (req_st == REQ_BANG && rx == CH_R)
                req_st = REQ_R;
            else if (req_st == REQ_R && rx == CH_S)
                req_st = REQ_S;
            else if (req_st == REQ_S && rx == CH_T)
                req_st = REQ_T;
            else if (req_st == REQ_T && rx == CH_HASH)
            begin
                if (pend != PEND_MAX)
                    pend = pend + 1'b1;
                req_st = REQ_IDLE;
            end
            else
                req_st = REQ_IDLE;

            if (rx == CH_BANG && waiting)
                ack_st = ACK_BANG;
            else if (ack_st == ACK_BANG && rx == CH_O)
                ack_st = ACK_O;
            else if (ack_st == ACK_O && rx == CH_K)
                ack_st = ACK_K;
            else if (ack_st == ACK_K && rx == CH_HASH)
            begin
                tmo_count = {1'b0, tmo_reload};
                waiting   = 1'b0;
                ack_st    = ACK_IDLE;
            end
            else
                ack_st = ACK_IDLE;
        end
        else if (waiting)
        begin
            if (tmo_count == 0)
            begin
                tmo_count = {1'b0, tmo_reload};
                hit       = 1'b1;
                r.kind    = KIND_REPEAT;
                r.value   = held_value;
                return;
            end
            tmo_count = tmo_count - 1'b1;
        end

        if (pend != 0 && !waiting)
        begin
            pend       = pend - 1'b1;
            held_value = smp;
            waiting    = 1'b1;
            hit        = 1'b1;
            r.kind     = KIND_NEW;
            r.value    = held_value;
        end
    endfunction

    task automatic send_item(input op_t op, input logic [BYTE_W-1:0] rx,
                             input logic [SAMPLE_W-1:0] smp, input bit pinned = 1'b0,
                             input bit pinned_hit = 1'b0, input reply_t pinned_due = '0);
        bit     hit;
        reply_t due;
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(24, 80)
                                                      : $urandom_range(1, 10);
        end
        item_ch.valid      <= 1'b1;
        item_ch.op         <= op;
        item_ch.rx_byte    <= rx;
        item_ch.adc_sample <= smp;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        items_sent++;
        predict_reply(op, rx, smp, hit, due);
        if (pinned)
        begin
            hit = pinned_hit;
            due = pinned_due;
        end
        if (hit)
            due_replies.push_back(due);
        burst_left--;
        if (burst_left == 0)
            item_ch.valid <= 1'b0;
    endtask

    task automatic send_text(input logic [39:0] text, input int unsigned len,
                             input bit garble);
        int unsigned       spot;
        logic [BYTE_W-1:0] ch;
        spot = garble ? $urandom_range(0, len - 1) : len;
        for (int unsigned i = 0; i < len; i++)
        begin
            ch = text[8 * (len - 1 - i) +: 8];
            if (i == spot)
                ch = 8'($urandom_range(0, 255));
            send_item(OP_BYTE, ch, 12'($urandom_range(0, 4095)));
        end
    endtask

    task automatic send_random_sequence();
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            send_text(REQUEST_TEXT, 5, $urandom_range(0, 5) == 0);
        else if (pick < 60)
            send_text(ACK_TEXT, 4, $urandom_range(0, 5) == 0);
        else if (pick < 85)
        begin
            len = (tmo_reload < 8) ? $urandom_range(1, tmo_reload + 3) : $urandom_range(1, 6);
            repeat (len)
                send_item(OP_TICK, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)));
        end
        else
        begin
            len = $urandom_range(1, 3);
            repeat (len)
                send_item(OP_BYTE, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)));
        end
    endtask

    task automatic hold_items();
        if (burst_left != 0)
        begin
            item_ch.valid <= 1'b0;
            burst_left = 0;
        end
    endtask

    task automatic load_timeout(input logic [TICKS_W-1:0] value);
        hold_items();
        while (due_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        tmo_reload = value;
    endtask

    // reply side: check each transfer, then pick the next ready level
    initial
    begin : reply_side
        stall_mode_t mode;
        int unsigned span;
        logic [7:0]  pattern;
        reply_t      want;
        reply_ch.ready = 1'b0;
        mode    = STALL_NONE;
        span    = 0;
        pattern = '0;
        forever
        begin
            @(posedge clk);
            if (reply_ch.valid && reply_ch.ready)
            begin
                if (due_replies.size() == 0)
                begin
                    $error("unexpected reply: reply_kind %0d reply_value 0x%03h",
                           reply_ch.reply_kind, reply_ch.reply_value);
                    error_count++;
                end
                else
                begin
                    want = due_replies.pop_front();
                    if (reply_ch.reply_kind !== want.kind)
                    begin
                        $error("reply_kind: expected %0d, got %0d",
                               want.kind, reply_ch.reply_kind);
                        error_count++;
                    end
                    if (reply_ch.reply_value !== want.value)
                    begin
                        $error("reply_value: expected 0x%03h, got 0x%03h",
                               want.value, reply_ch.reply_value);
                        error_count++;
                    end
                end
            end
            if (span == 0)
            begin
                mode    = stall_mode_t'($urandom_range(0, 3));
                span    = $urandom_range(8, 80);
                pattern = 8'($urandom);
            end
            span--;
            case (mode)
                STALL_NONE:    reply_ch.ready <= 1'b1;
                STALL_COIN:    reply_ch.ready <= 1'($urandom_range(0, 1));
                STALL_PATTERN:
                begin
                    reply_ch.ready <= pattern[0];
                    pattern = {pattern[0], pattern[7:1]};
                end
                default:       reply_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (reply_ch.valid && reply_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("command_ack_retransmit_handler_tb: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned goal;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        item_ch.valid      = 1'b0;
        item_ch.op         = OP_BYTE;
        item_ch.rx_byte    = '0;
        item_ch.adc_sample = '0;

        script = '{
            '{OP_TICK, 8'h00,   12'hABC, 1'b1, 1'b0, '0},
            '{OP_BYTE, 8'hFF,   12'h000, 1'b1, 1'b0, '0},
            '{OP_BYTE, 8'h00,   12'hFFF, 1'b1, 1'b0, '0},
            '{OP_BYTE, CH_BANG, 12'h123, 1'b0, 1'b0, '0},
            '{OP_BYTE, CH_R,    12'h456, 1'b0, 1'b0, '0},
            '{OP_BYTE, CH_S,    12'h789, 1'b0, 1'b0, '0},
            '{OP_BYTE, CH_T,    12'h000, 1'b0, 1'b0, '0},
            '{OP_BYTE, CH_HASH, 12'hFFF, 1'b1, 1'b1, '{KIND_NEW, 12'hFFF}},
            '{OP_TICK, 8'hFF,   12'h000, 1'b0, 1'b0, '0},
            '{OP_BYTE, CH_BANG, 12'h111, 1'b0, 1'b0, '0},
            '{OP_BYTE, CH_O,    12'h222, 1'b0, 1'b0, '0},
            '{OP_BYTE, CH_K,    12'h333, 1'b0, 1'b0, '0},
            '{OP_BYTE, CH_HASH, 12'h444, 1'b0, 1'b0, '0},
            '{OP_BYTE, CH_BANG, 12'h555, 1'b0, 1'b0, '0},
            '{OP_BYTE, CH_R,    12'h666, 1'b0, 1'b0, '0},
            '{OP_BYTE, CH_S,    12'h777, 1'b0, 1'b0, '0},
            '{OP_BYTE, CH_T,    12'h888, 1'b0, 1'b0, '0},
            '{OP_BYTE, CH_HASH, 12'h5A5, 1'b1, 1'b1, '{KIND_NEW, 12'h5A5}},
            '{OP_TICK, 8'h0F,   12'h999, 1'b0, 1'b0, '0},
            '{OP_TICK, 8'h00,   12'h000, 1'b1, 1'b1, '{KIND_REPEAT, 12'h5A5}},
            '{OP_TICK, 8'hF0,   12'hAAA, 1'b0, 1'b0, '0},
            '{OP_TICK, 8'h55,   12'hBBB, 1'b0, 1'b0, '0},
            '{OP_BYTE, CH_BANG, 12'hCCC, 1'b0, 1'b0, '0},
            '{OP_BYTE, CH_O,    12'hDDD, 1'b0, 1'b0, '0},
            '{OP_BYTE, CH_K,    12'hEEE, 1'b0, 1'b0, '0},
            '{OP_BYTE, CH_HASH, 12'h001, 1'b0, 1'b0, '0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // the first wait still runs from the reset count
        load_timeout(16'd1);
        for (int i = 0; i < SCRIPT_LEN; i++)
            send_item(script[i].op, script[i].rx, script[i].smp,
                      script[i].pinned, script[i].hit, script[i].due);

        for (int p = 0; p < 8; p++)
        begin
            load_timeout((p == 6) ? 16'($urandom_range(0, 65535)) : RELOAD_PLAN[p]);
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal)
                send_random_sequence();
        end

        hold_items();
        while (due_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("command_ack_retransmit_handler_tb: PASS");
        else
            $display("command_ack_retransmit_handler_tb: FAIL");
        $finish;
    end

endmodule
